// File: sv/mcg_pkg.sv
// shared types and constants for the midpoint circle generator
package mcg_pkg;

  localparam int COORD_BITS  = 11;
  localparam int RADIUS_BITS = 10;
  localparam int DEC_BITS    = RADIUS_BITS + 3;
  localparam int PIX_BITS    = 13;

  localparam int Q_DEPTH     = 2;
  localparam int Q_PTR_BITS  = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_BITS  = $clog2(Q_DEPTH + 1);

  typedef enum logic {
    KIND_START   = 1'b0,
    KIND_ADVANCE = 1'b1
  } kind_t;

  typedef enum logic [2:0] {
    OCT_0 = 3'd0,
    OCT_1 = 3'd1,
    OCT_2 = 3'd2,
    OCT_3 = 3'd3,
    OCT_4 = 3'd4,
    OCT_5 = 3'd5,
    OCT_6 = 3'd6,
    OCT_7 = 3'd7
  } oct_t;

  // one step of the circle, handed from front to back
  typedef struct packed {
    logic [COORD_BITS-1:0]  origin_x;
    logic [COORD_BITS-1:0]  origin_y;
    logic [RADIUS_BITS-1:0] offset_x;
    logic [RADIUS_BITS-1:0] offset_y;
    logic                   done;
  } step_t;

  // queue handshake between the parts
  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

endpackage

// File: sv/mcg_front.sv
// front part: accepts items, runs the midpoint step and queues each step
module mcg_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_kind,
  input  logic [mcg_pkg::COORD_BITS-1:0]  in_center_x,
  input  logic [mcg_pkg::COORD_BITS-1:0]  in_center_y,
  input  logic [mcg_pkg::RADIUS_BITS-1:0] in_radius,
  input  mcg_pkg::q_status_t             q_status,
  output logic                           q_push,
  output mcg_pkg::step_t                 q_wdata
);
  import mcg_pkg::*;

  logic [RADIUS_BITS-1:0] offset_x_r, offset_x_nxt;
  logic [RADIUS_BITS-1:0] offset_y_r, offset_y_nxt;
  logic [DEC_BITS-1:0]    decision_r, decision_nxt;
  logic [COORD_BITS-1:0]  origin_x_r, origin_x_nxt;
  logic [COORD_BITS-1:0]  origin_y_r, origin_y_nxt;
  logic                   active_r, active_nxt;
  logic                   accept;
  logic                   start;
  logic [DEC_BITS-1:0]    x2, y2;

  assign in_stall = q_status.full;
  assign accept   = in_valid && !in_stall;
  assign start    = (in_kind == KIND_START);
  assign x2       = DEC_BITS'({offset_x_r, 1'b0});
  assign y2       = DEC_BITS'({offset_y_r, 1'b0});

  always_comb begin
    offset_x_nxt = offset_x_r;
    offset_y_nxt = offset_y_r;
    decision_nxt = decision_r;
    origin_x_nxt = origin_x_r;
    origin_y_nxt = origin_y_r;
    q_push       = 1'b0;
    if (accept && start) begin
      origin_x_nxt = in_center_x;
      origin_y_nxt = in_center_y;
      offset_x_nxt = '0;
      offset_y_nxt = in_radius;
      decision_nxt = DEC_BITS'(1) - DEC_BITS'(in_radius);
      q_push       = 1'b1;
    end else if (accept && active_r) begin
      if (decision_r[DEC_BITS-1]) begin
        decision_nxt = decision_r + x2 + DEC_BITS'(3);
      end else begin
        decision_nxt = decision_r + x2 - y2 + DEC_BITS'(5);
        offset_y_nxt = offset_y_r - RADIUS_BITS'(1);
      end
      offset_x_nxt = offset_x_r + RADIUS_BITS'(1);
      q_push       = 1'b1;
    end
    active_nxt = offset_x_nxt < offset_y_nxt;
  end

  always_comb begin
    q_wdata.origin_x = origin_x_nxt;
    q_wdata.origin_y = origin_y_nxt;
    q_wdata.offset_x = offset_x_nxt;
    q_wdata.offset_y = offset_y_nxt;
    q_wdata.done     = !active_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_x_r <= '0;
      offset_y_r <= '0;
      decision_r <= '0;
      origin_x_r <= '0;
      origin_y_r <= '0;
      active_r   <= 1'b0;
    end else begin
      offset_x_r <= offset_x_nxt;
      offset_y_r <= offset_y_nxt;
      decision_r <= decision_nxt;
      origin_x_r <= origin_x_nxt;
      origin_y_r <= origin_y_nxt;
      // an inactive advance leaves everything as is
      if (q_push) begin
        active_r <= active_nxt;
      end
    end
  end

endmodule

// File: sv/mcg_queue.sv
// short step queue between front and back
module mcg_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  mcg_pkg::step_t     wdata,
  input  logic               pop,
  output mcg_pkg::step_t     rdata,
  output mcg_pkg::q_status_t status
);
  import mcg_pkg::*;

  step_t                 entry_r [Q_DEPTH];
  logic [Q_PTR_BITS-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_BITS-1:0] count_r;
  logic                  do_push, do_pop;

  assign status.empty = (count_r == '0);
  assign status.full  = (count_r == Q_CNT_BITS'(Q_DEPTH));
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign rdata        = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == Q_PTR_BITS'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + Q_PTR_BITS'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == Q_PTR_BITS'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + Q_PTR_BITS'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + Q_CNT_BITS'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - Q_CNT_BITS'(1);
      end
    end
  end

endmodule

// File: sv/mcg_back.sv
// back part: walks the eight symmetric points of each queued step
module mcg_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  mcg_pkg::q_status_t                  q_status,
  input  mcg_pkg::step_t                      q_rdata,
  output logic                                q_pop,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [mcg_pkg::PIX_BITS-1:0] out_pixel_x,
  output logic signed [mcg_pkg::PIX_BITS-1:0] out_pixel_y,
  output logic [2:0]                          out_octant,
  output logic                                out_last_of_step,
  output logic                                out_circle_done
);
  import mcg_pkg::*;

  step_t               cur_r;
  logic                cur_valid_r;
  oct_t                idx_r;
  logic                out_valid_r;
  logic [PIX_BITS-1:0] pix_x_r, pix_y_r;
  oct_t                oct_r;
  logic                last_r, done_r;

  logic                load;
  logic                step_end;
  logic [PIX_BITS-1:0] cx, cy, ox, oy, px, py;

  assign load     = cur_valid_r && (!out_valid_r || !out_stall);
  assign step_end = load && (idx_r == OCT_7);
  assign q_pop    = (!cur_valid_r || step_end) && !q_status.empty;

  assign cx = PIX_BITS'(cur_r.origin_x);
  assign cy = PIX_BITS'(cur_r.origin_y);
  assign ox = PIX_BITS'(cur_r.offset_x);
  assign oy = PIX_BITS'(cur_r.offset_y);

  always_comb begin
    case (idx_r)
      OCT_0: begin px = cx + ox; py = cy + oy; end
      OCT_1: begin px = cx + oy; py = cy + ox; end
      OCT_2: begin px = cx + oy; py = cy - ox; end
      OCT_3: begin px = cx + ox; py = cy - oy; end
      OCT_4: begin px = cx - ox; py = cy - oy; end
      OCT_5: begin px = cx - oy; py = cy - ox; end
      OCT_6: begin px = cx - oy; py = cy + ox; end
      OCT_7: begin px = cx - ox; py = cy + oy; end
      default: begin px = cx; py = cy; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_rdata;
    end
    if (load) begin
      pix_x_r <= px;
      pix_y_r <= py;
      oct_r   <= idx_r;
      last_r  <= (idx_r == OCT_7);
      done_r  <= cur_r.done;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= OCT_0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        cur_valid_r <= 1'b1;
        idx_r       <= OCT_0;
      end else if (step_end) begin
        cur_valid_r <= 1'b0;
        idx_r       <= OCT_0;
      end else if (load) begin
        idx_r <= oct_t'(idx_r + 3'd1);
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pixel_x      = signed'(pix_x_r);
  assign out_pixel_y      = signed'(pix_y_r);
  assign out_octant       = oct_r;
  assign out_last_of_step = last_r;
  assign out_circle_done  = done_r;

endmodule

// File: sv/midpoint_circle_generator.sv
// midpoint circle generator top level: front, step queue and point back end
// first point of a step passes the queue entry, the back end's step register and the output register
// a step yields eight points on consecutive cycles unless the output stalls
// the single result port bounds how fast emitting items drain; an advance with no active circle yields no points
// the two-entry step queue lets up to two further items be taken while points drain
// synchronous active-low reset clears circle state, queue and output valid
module midpoint_circle_generator (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_kind,
  input  logic [mcg_pkg::COORD_BITS-1:0]       in_center_x,
  input  logic [mcg_pkg::COORD_BITS-1:0]       in_center_y,
  input  logic [mcg_pkg::RADIUS_BITS-1:0]      in_radius,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [mcg_pkg::PIX_BITS-1:0] out_pixel_x,
  output logic signed [mcg_pkg::PIX_BITS-1:0] out_pixel_y,
  output logic [2:0]                          out_octant,
  output logic                                out_last_of_step,
  output logic                                out_circle_done
);
  import mcg_pkg::*;

  q_status_t q_status;
  logic      q_push, q_pop;
  step_t     q_wdata, q_rdata;

  mcg_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_kind     (in_kind),
    .in_center_x (in_center_x),
    .in_center_y (in_center_y),
    .in_radius   (in_radius),
    .q_status    (q_status),
    .q_push      (q_push),
    .q_wdata     (q_wdata)
  );

  mcg_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wdata  (q_wdata),
    .pop    (q_pop),
    .rdata  (q_rdata),
    .status (q_status)
  );

  mcg_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_status         (q_status),
    .q_rdata          (q_rdata),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_pixel_x      (out_pixel_x),
    .out_pixel_y      (out_pixel_y),
    .out_octant       (out_octant),
    .out_last_of_step (out_last_of_step),
    .out_circle_done  (out_circle_done)
  );

endmodule

// File: sv/mcg_checker.sv
// port checks for the midpoint circle generator and their bind
module mcg_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic signed [mcg_pkg::PIX_BITS-1:0] out_pixel_x,
  input logic signed [mcg_pkg::PIX_BITS-1:0] out_pixel_y,
  input logic [2:0]                          out_octant,
  input logic                                out_last_of_step,
  input logic                                out_circle_done
);
  import mcg_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pixel_x) && $stable(out_pixel_y)
      && $stable(out_octant))
    else $error("stalled result changed");

  // points of a step leave back to back in octant order
  a_oct_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_octant != OCT_7
      |=> out_valid && out_octant == $past(out_octant) + 3'd1)
    else $error("octant sequence broken");

  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_last_of_step == (out_octant == OCT_7))
    else $error("last_of_step does not match octant");

  // done flag is the same on all points of a step
  a_done_const: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_of_step |=> out_circle_done == $past(out_circle_done))
    else $error("circle_done changed within a step");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind midpoint_circle_generator mcg_checker u_mcg_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_pixel_x      (out_pixel_x),
  .out_pixel_y      (out_pixel_y),
  .out_octant       (out_octant),
  .out_last_of_step (out_last_of_step),
  .out_circle_done  (out_circle_done)
);
